FILE: hw/rtl/cimd_pkg.sv
`default_nettype none

package cimd_pkg;

    typedef logic [31:0] insn_t;
    typedef logic [5:0]  opnum_t;
    typedef logic [5:0]  grp_en_t;

    localparam grp_en_t GRP_EN_RESET = 6'h3F;

    localparam int GRP_SHADD  = 0;
    localparam int GRP_BITMAN = 1;
    localparam int GRP_BITTST = 2;
    localparam int GRP_CMOV   = 3;
    localparam int GRP_MAC    = 4;
    localparam int GRP_MEMIDX = 5;

    localparam logic [6:0] OPC_CUSTOM0 = 7'b0001011;

    localparam logic [2:0] F3_ALU   = 3'd1;
    localparam logic [2:0] F3_EXT   = 3'd2;
    localparam logic [2:0] F3_EXTU  = 3'd3;
    localparam logic [2:0] F3_LDIDX = 3'd4;
    localparam logic [2:0] F3_STIDX = 3'd5;

    localparam logic [6:0] F7_SRRIW  = 7'h0A;
    localparam logic [6:0] F7_TSTNBZ = 7'h40;
    localparam logic [6:0] F7_REV    = 7'h41;
    localparam logic [6:0] F7_FF0    = 7'h42;
    localparam logic [6:0] F7_FF1    = 7'h43;
    localparam logic [6:0] F7_REVW_A = 7'h44;
    localparam logic [6:0] F7_REVW_B = 7'h48;
    localparam logic [6:0] F7_SRRI_A = 7'h08;
    localparam logic [6:0] F7_SRRI_B = 7'h09;
    localparam logic [6:0] F7_MVEQZ  = 7'h20;
    localparam logic [6:0] F7_MVNEZ  = 7'h21;
    localparam logic [6:0] F7_MAC_LO = 7'h10;
    localparam logic [6:0] F7_MAC_HI = 7'h15;
    localparam logic [5:0] F7_TST_HI = 6'h22;
    localparam logic [6:0] F7_SHADD_MAX = 7'h03;
    localparam logic [4:0] F5_LD_MAX = 5'd27;
    localparam logic [4:0] F5_ST_MAX = 5'd15;

    localparam opnum_t OP_ADDSL  = 6'd0;
    localparam opnum_t OP_SRRIW  = 6'd1;
    localparam opnum_t OP_TSTNBZ = 6'd2;
    localparam opnum_t OP_REV    = 6'd3;
    localparam opnum_t OP_FF0    = 6'd4;
    localparam opnum_t OP_FF1    = 6'd5;
    localparam opnum_t OP_REVW   = 6'd6;
    localparam opnum_t OP_SRRI   = 6'd7;
    localparam opnum_t OP_EXT    = 6'd8;
    localparam opnum_t OP_EXTU   = 6'd9;
    localparam opnum_t OP_TST    = 6'd10;
    localparam opnum_t OP_MVEQZ  = 6'd11;
    localparam opnum_t OP_MVNEZ  = 6'd12;
    localparam opnum_t OP_MAC0   = 6'd13;
    localparam opnum_t OP_LDIDX0 = 6'd19;
    localparam opnum_t OP_STIDX0 = 6'd47;
    localparam opnum_t OP_LAST   = 6'd62;

endpackage

`default_nettype wire

FILE: hw/rtl/custom_integer_memidx_decoder.sv
// Pipeline: an accepted word is held in the input register, then decoded
//   into the result register.
// Throughput: one word per cycle; input register and result register each
//   stall only when the stage after them is full and not draining.
// Reset: synchronous, active-low aresetn clears both stage valids and sets
//   group_enable to all groups enabled.
`default_nettype none

module custom_integer_memidx_decoder (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    cfg_wr_en,
    input  cimd_pkg::grp_en_t      cfg_wr_data,   // group_enable
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  cimd_pkg::insn_t        s_tdata,       // [31:0] instruction
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [7:0]             m_tdata,       // [5:0] opcode_number, [7:6] zero
    output logic                   m_tuser        // [0] recognized
);
    import cimd_pkg::*;

    grp_en_t grp_en_reg;
    logic    in_valid_reg;
    insn_t   insn_reg;
    logic    out_valid_reg;
    logic    hit_reg;
    opnum_t  opnum_reg;

    logic    out_adv;
    logic    in_adv;
    logic    hit_next;
    opnum_t  opnum_next;

    assign out_adv  = !out_valid_reg || m_tready;
    assign in_adv   = !in_valid_reg || out_adv;
    assign s_tready = in_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_en_reg <= GRP_EN_RESET;
        end else if (cfg_wr_en) begin
            grp_en_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_adv) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && s_tvalid) begin
            insn_reg <= s_tdata;
        end
        if (out_adv && in_valid_reg) begin
            hit_reg   <= hit_next;
            opnum_reg <= opnum_next;
        end
    end

    always_comb begin
        logic [2:0] f3;
        logic [6:0] f7;
        logic [4:0] f5;
        logic [4:0] rs2;
        logic       rs2_z;
        logic       sa_hit, bm_hit, bt_hit, cm_hit, ma_hit, mi_hit;
        opnum_t     bm_num, cm_num, ma_num, mi_num;

        f3    = insn_reg[14:12];
        f7    = insn_reg[31:25];
        f5    = insn_reg[31:27];
        rs2   = insn_reg[24:20];
        rs2_z = (rs2 == 5'd0);

        sa_hit = (f3 == F3_ALU) && (f7 <= F7_SHADD_MAX);

        bm_hit = 1'b0;
        bm_num = OP_EXT;
        if (f3 == F3_EXT) begin
            bm_hit = 1'b1;
            bm_num = OP_EXT;
        end else if (f3 == F3_EXTU) begin
            bm_hit = 1'b1;
            bm_num = OP_EXTU;
        end else if (f3 == F3_ALU) begin
            case (f7)
                F7_SRRIW: begin
                    bm_hit = 1'b1;
                    bm_num = OP_SRRIW;
                end
                F7_TSTNBZ: begin
                    bm_hit = rs2_z;
                    bm_num = OP_TSTNBZ;
                end
                F7_REV: begin
                    bm_hit = rs2_z;
                    bm_num = OP_REV;
                end
                F7_FF0: begin
                    bm_hit = rs2_z;
                    bm_num = OP_FF0;
                end
                F7_FF1: begin
                    bm_hit = rs2_z;
                    bm_num = OP_FF1;
                end
                F7_REVW_A, F7_REVW_B: begin
                    bm_hit = rs2_z;
                    bm_num = OP_REVW;
                end
                F7_SRRI_A, F7_SRRI_B: begin
                    bm_hit = 1'b1;
                    bm_num = OP_SRRI;
                end
                default: begin
                    bm_hit = 1'b0;
                end
            endcase
        end

        bt_hit = (f3 == F3_ALU) && (f7[6:1] == F7_TST_HI);

        cm_hit = (f3 == F3_ALU) && ((f7 == F7_MVEQZ) || (f7 == F7_MVNEZ));
        cm_num = (f7 == F7_MVNEZ) ? OP_MVNEZ : OP_MVEQZ;

        ma_hit = (f3 == F3_ALU) && (f7 >= F7_MAC_LO) && (f7 <= F7_MAC_HI);
        ma_num = OP_MAC0 + {3'b000, f7[2:0]};

        mi_hit = ((f3 == F3_LDIDX) && (f5 <= F5_LD_MAX))
              || ((f3 == F3_STIDX) && (f5 <= F5_ST_MAX));
        mi_num = ((f3 == F3_LDIDX) ? OP_LDIDX0 : OP_STIDX0) + {1'b0, f5};

        hit_next   = 1'b0;
        opnum_next = '0;
        if (insn_reg[6:0] == OPC_CUSTOM0) begin
            if (grp_en_reg[GRP_SHADD] && sa_hit) begin
                hit_next   = 1'b1;
                opnum_next = OP_ADDSL;
            end else if (grp_en_reg[GRP_BITMAN] && bm_hit) begin
                hit_next   = 1'b1;
                opnum_next = bm_num;
            end else if (grp_en_reg[GRP_BITTST] && bt_hit) begin
                hit_next   = 1'b1;
                opnum_next = OP_TST;
            end else if (grp_en_reg[GRP_CMOV] && cm_hit) begin
                hit_next   = 1'b1;
                opnum_next = cm_num;
            end else if (grp_en_reg[GRP_MAC] && ma_hit) begin
                hit_next   = 1'b1;
                opnum_next = ma_num;
            end else if (grp_en_reg[GRP_MEMIDX] && mi_hit) begin
                hit_next   = 1'b1;
                opnum_next = mi_num;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, opnum_reg};
    assign m_tuser  = hit_reg;

`ifndef NO_ASSERTIONS
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 8'd0))
        else $error("unrecognized word carries nonzero opcode number");

    a_op_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= {2'b00, OP_LAST}))
        else $error("opcode number out of range");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline is full and stalled");

    a_pipe_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_adv) |=> m_tvalid)
        else $error("decoded word lost between stages");
`endif

endmodule

`default_nettype wire

FILE: bench/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cimd_pkg::*;

    typedef struct packed {
        logic   recognized;
        opnum_t opnum;
    } decode_t;

    typedef struct {
        grp_en_t groups;
        insn_t   word;
        bit      typed;
        decode_t want;
    } vec_t;

    localparam decode_t UNRECOGNIZED = '0;
    localparam int      CYCLE_LIMIT  = 200000;
    localparam int      PHASES       = 8;
    localparam int      PHASE_WORDS  = 250;
    localparam logic [6:0] F7_HOT [12] = '{F7_SRRIW, F7_TSTNBZ, F7_REV, F7_FF0, F7_FF1,
        F7_REVW_A, F7_REVW_B, F7_SRRI_A, F7_SRRI_B, F7_MVEQZ, F7_MVNEZ, {F7_TST_HI, 1'b1}};

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    cfg_wr_en = 1'b0;
    grp_en_t cfg_wr_data = '0;
    logic    s_tvalid = 1'b0;
    logic    s_tready;
    insn_t   s_tdata = '0;
    logic    m_tvalid;
    logic    m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic    m_tuser;

    custom_integer_memidx_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #6 aclk = ~aclk;

    decode_t pending_decodes[$];
    grp_en_t groups_now = GRP_EN_RESET;
    bit      quiet = 1'b0;
    int      mismatches = 0;
    int      cycles = 0;
    decode_t got_want;
    vec_t    vecs[$];
    grp_en_t phase_groups[PHASES];

    function automatic decode_t decode_word(insn_t w, grp_en_t en);
        logic [2:0] f3;
        logic [6:0] f7;
        logic [4:0] f5;
        logic [4:0] rs2;
        decode_t    d;
        f3  = w[14:12];
        f7  = w[31:25];
        f5  = w[31:27];
        rs2 = w[24:20];
        d   = UNRECOGNIZED;
        if (w[6:0] == OPC_CUSTOM0) begin
            if (!d.recognized && en[GRP_SHADD] && f3 == F3_ALU && f7 <= F7_SHADD_MAX) begin
                d = '{1'b1, OP_ADDSL};
            end
            if (!d.recognized && en[GRP_BITMAN]) begin
                if (f3 == F3_EXT) begin
                    d = '{1'b1, OP_EXT};
                end else if (f3 == F3_EXTU) begin
                    d = '{1'b1, OP_EXTU};
                end else if (f3 == F3_ALU) begin
                    case (f7)
                        F7_SRRIW: d = '{1'b1, OP_SRRIW};
                        F7_TSTNBZ: if (rs2 == '0) d = '{1'b1, OP_TSTNBZ};
                        F7_REV: if (rs2 == '0) d = '{1'b1, OP_REV};
                        F7_FF0: if (rs2 == '0) d = '{1'b1, OP_FF0};
                        F7_FF1: if (rs2 == '0) d = '{1'b1, OP_FF1};
                        F7_REVW_A, F7_REVW_B: if (rs2 == '0) d = '{1'b1, OP_REVW};
                        F7_SRRI_A, F7_SRRI_B: d = '{1'b1, OP_SRRI};
                        default: ;
                    endcase
                end
            end
            if (!d.recognized && en[GRP_BITTST] && f3 == F3_ALU && f7[6:1] == F7_TST_HI) begin
                d = '{1'b1, OP_TST};
            end
            if (!d.recognized && en[GRP_CMOV] && f3 == F3_ALU) begin
                if (f7 == F7_MVEQZ) d = '{1'b1, OP_MVEQZ};
                else if (f7 == F7_MVNEZ) d = '{1'b1, OP_MVNEZ};
            end
            if (!d.recognized && en[GRP_MAC] && f3 == F3_ALU
                && f7 >= F7_MAC_LO && f7 <= F7_MAC_HI) begin
                d = '{1'b1, OP_MAC0 + 6'(f7 - F7_MAC_LO)};
            end
            if (!d.recognized && en[GRP_MEMIDX]) begin
                if (f3 == F3_LDIDX && f5 <= F5_LD_MAX) d = '{1'b1, OP_LDIDX0 + 6'(f5)};
                else if (f3 == F3_STIDX && f5 <= F5_ST_MAX) d = '{1'b1, OP_STIDX0 + 6'(f5)};
            end
        end
        return d;
    endfunction

    function automatic insn_t make_insn(logic [6:0] f7, logic [4:0] rs2, logic [2:0] f3);
        return {f7, rs2, 5'd7, f3, 5'd9, OPC_CUSTOM0};
    endfunction

    // mostly custom-0 words with hot funct fields, some near misses and raw noise
    function automatic insn_t random_insn();
        insn_t w;
        int    pick;
        w    = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            w[6:0] = OPC_CUSTOM0;
            if ($urandom_range(0, 9) < 8) w[14:12] = 3'($urandom_range(1, 5));
            case ($urandom_range(0, 3))
                0: w[31:25] = F7_HOT[$urandom_range(0, 11)];
                1: w[31:25] = F7_MAC_LO + 7'($urandom_range(0, 6));
                2: w[31:25] = 7'($urandom_range(0, 4));
                default: ;
            endcase
            if ($urandom_range(0, 1) == 0) w[24:20] = '0;
        end else if (pick < 93) begin
            w[6:0] = OPC_CUSTOM0 ^ (7'd1 << $urandom_range(0, 6));
        end
        return w;
    endfunction

    task automatic add_row(grp_en_t en, insn_t w, bit typed, decode_t want);
        vecs.push_back('{en, w, typed, want});
    endtask

    // entered and left at a falling edge
    task automatic push_word(insn_t w, bit typed, decode_t want);
        while (!quiet && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        pending_decodes.push_back(typed ? want : decode_word(w, groups_now));
    endtask

    task automatic write_groups(grp_en_t en);
        s_tvalid <= 1'b0;
        while (pending_decodes.size() != 0) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        groups_now  = en;
    endtask

    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 19);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_decodes.size() == 0) begin
                $error("result word with nothing expected: tuser %0b tdata %0h",
                       m_tuser, m_tdata);
                mismatches++;
            end else begin
                got_want = pending_decodes.pop_front();
                if (m_tuser !== got_want.recognized) begin
                    $error("recognized: expected %0b, got %0b", got_want.recognized, m_tuser);
                    mismatches++;
                end
                if (m_tdata[5:0] !== got_want.opnum) begin
                    $error("opcode_number: expected %0d, got %0d", got_want.opnum,
                           m_tdata[5:0]);
                    mismatches++;
                end
                if (m_tdata[7:6] !== 2'b00) begin
                    $error("tdata pad: expected 0, got %0b", m_tdata[7:6]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        add_row(GRP_EN_RESET, 32'h0000_0000, 1'b1, UNRECOGNIZED);
        add_row(GRP_EN_RESET, 32'hFFFF_FFFF, 1'b1, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_SHADD_MAX, 5'd31, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_SRRIW, 5'd5, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_TSTNBZ, 5'd0, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_TSTNBZ, 5'd1, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_REV, 5'd0, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_FF0, 5'd0, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_FF1, 5'd0, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_REVW_A, 5'd0, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_REVW_B, 5'd0, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_SRRI_A, 5'd17, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_SRRI_B, 5'd31, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(7'h7F, 5'd31, F3_EXT), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(7'h00, 5'd0, F3_EXTU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn({F7_TST_HI, 1'b1}, 5'd9, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_MVEQZ, 5'd3, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_MVNEZ, 5'd4, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_MAC_LO, 5'd2, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn(F7_MAC_HI, 5'd2, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn({5'd0, 2'b00}, 5'd0, F3_LDIDX), 1'b1,
                '{1'b1, OP_LDIDX0});
        add_row(GRP_EN_RESET, make_insn({F5_LD_MAX, 2'b11}, 5'd31, F3_LDIDX), 1'b0,
                UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn({F5_LD_MAX + 5'd1, 2'b00}, 5'd0, F3_LDIDX), 1'b0,
                UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn({F5_ST_MAX, 2'b10}, 5'd8, F3_STIDX), 1'b0,
                UNRECOGNIZED);
        add_row(GRP_EN_RESET, make_insn({F5_ST_MAX + 5'd1, 2'b01}, 5'd8, F3_STIDX), 1'b0,
                UNRECOGNIZED);
        // revw encoding falls through to tst with bit manipulation off
        add_row(GRP_EN_RESET & ~(grp_en_t'(1) << GRP_BITMAN),
                make_insn(F7_REVW_A, 5'd0, F3_ALU), 1'b0, UNRECOGNIZED);
        add_row('0, make_insn(F7_TSTNBZ, 5'd0, F3_ALU), 1'b1, UNRECOGNIZED);

        phase_groups = '{GRP_EN_RESET, '0, GRP_EN_RESET & ~(grp_en_t'(1) << GRP_BITMAN),
                         grp_en_t'(1) << GRP_SHADD, grp_en_t'(1) << GRP_MEMIDX,
                         GRP_EN_RESET & ~(grp_en_t'(1) << GRP_SHADD),
                         grp_en_t'($urandom()), grp_en_t'($urandom())};

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < vecs.size(); i++) begin
            if (vecs[i].groups != groups_now) write_groups(vecs[i].groups);
            push_word(vecs[i].word, vecs[i].typed, vecs[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_groups(phase_groups[p]);
            quiet = (p == 3);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                push_word(random_insn(), 1'b0, UNRECOGNIZED);
            end
        end
        quiet = 1'b0;

        s_tvalid <= 1'b0;
        while (pending_decodes.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
